>>> hdl/fpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared constants for the Fermat primality test pipeline.
// ----------------------------------------------------------------------------
package fpt_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 31;

endpackage
`default_nettype wire

>>> hdl/fpt_red_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_red_cell
// One restoring division step that reduces the base modulo the candidate.
// ----------------------------------------------------------------------------
module fpt_red_cell #(
   parameter int OPERAND_WIDTH = fpt_pkg::OPERAND_WIDTH_DEFAULT,
   parameter int BIT           = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     valid_i,
   input  wire logic [OPERAND_WIDTH-1:0] base_i,
   input  wire logic [OPERAND_WIDTH-1:0] modulus_i,
   input  wire logic [OPERAND_WIDTH-1:0] rem_i,
   output logic                          valid_o,
   output logic [OPERAND_WIDTH-1:0]      base_o,
   output logic [OPERAND_WIDTH-1:0]      modulus_o,
   output logic [OPERAND_WIDTH-1:0]      rem_o
);
   import fpt_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic         valid_ff;
   logic [W-1:0] base_ff, modulus_ff, rem_ff, rem_in;
   logic [W:0]   shifted;

   always_comb begin
      shifted = {rem_i, base_i[BIT]};
      if (shifted >= {1'b0, modulus_i}) begin
         shifted = shifted - {1'b0, modulus_i};
      end
      rem_in = shifted[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      base_ff    <= base_i;
      modulus_ff <= modulus_i;
      rem_ff     <= rem_in;
   end

   assign valid_o   = valid_ff;
   assign base_o    = base_ff;
   assign modulus_o = modulus_ff;
   assign rem_o     = rem_ff;
endmodule
`default_nettype wire

>>> hdl/fpt_mul_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_mul_cell
// One interleaved modular multiply step for both the running product and the
// square; the cell on the lowest multiplier bit closes one exponent bit.
// ----------------------------------------------------------------------------
module fpt_mul_cell #(
   parameter int OPERAND_WIDTH = fpt_pkg::OPERAND_WIDTH_DEFAULT,
   parameter int BIT           = 0,
   parameter int EXP           = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     valid_i,
   input  wire logic [OPERAND_WIDTH-1:0] modulus_i,
   input  wire logic [OPERAND_WIDTH-1:0] ared_i,
   input  wire logic [OPERAND_WIDTH-1:0] acc_i,
   input  wire logic [OPERAND_WIDTH-1:0] sq_i,
   input  wire logic [OPERAND_WIDTH-1:0] r1_i,
   input  wire logic [OPERAND_WIDTH-1:0] r2_i,
   output logic                          valid_o,
   output logic [OPERAND_WIDTH-1:0]      modulus_o,
   output logic [OPERAND_WIDTH-1:0]      ared_o,
   output logic [OPERAND_WIDTH-1:0]      acc_o,
   output logic [OPERAND_WIDTH-1:0]      sq_o,
   output logic [OPERAND_WIDTH-1:0]      r1_o,
   output logic [OPERAND_WIDTH-1:0]      r2_o
);
   import fpt_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic         valid_ff;
   logic [W-1:0] modulus_ff, ared_ff, acc_ff, sq_ff, r1_ff, r2_ff;
   logic [W-1:0] acc_in, sq_in, r1_in, r2_in;
   logic [W-1:0] r1_step, r2_step;
   logic [W:0]   t1, t2, m;

   always_comb begin
      m  = {1'b0, modulus_i};
      t1 = {r1_i, 1'b0};
      t2 = {r2_i, 1'b0};
      if (t1 >= m) begin
         t1 = t1 - m;
      end
      if (t2 >= m) begin
         t2 = t2 - m;
      end
      if (sq_i[BIT]) begin
         t1 = t1 + {1'b0, acc_i};
         t2 = t2 + {1'b0, sq_i};
      end
      if (t1 >= m) begin
         t1 = t1 - m;
      end
      if (t2 >= m) begin
         t2 = t2 - m;
      end
      r1_step = t1[W-1:0];
      r2_step = t2[W-1:0];
      if (BIT == 0) begin
         acc_in = modulus_i[EXP] ? r1_step : acc_i;
         sq_in  = r2_step;
         r1_in  = '0;
         r2_in  = '0;
      end else begin
         acc_in = acc_i;
         sq_in  = sq_i;
         r1_in  = r1_step;
         r2_in  = r2_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      modulus_ff <= modulus_i;
      ared_ff    <= ared_i;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      r1_ff      <= r1_in;
      r2_ff      <= r2_in;
   end

   assign valid_o   = valid_ff;
   assign modulus_o = modulus_ff;
   assign ared_o    = ared_ff;
   assign acc_o     = acc_ff;
   assign sq_o      = sq_ff;
   assign r1_o      = r1_ff;
   assign r2_o      = r2_ff;
endmodule
`default_nettype wire

>>> hdl/fermat_primality_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fermat_primality_test
// Fully pipelined Fermat test: checks whether the modulus divides a^p - a.
// ----------------------------------------------------------------------------
// A new word is taken in every cycle and busy is always low. Each word gives
// one result strobe after it passes the row of cells: OPERAND_WIDTH cells
// reduce the base, then OPERAND_WIDTH squaring rounds of OPERAND_WIDTH
// multiply cells each, then the output register. Results leave in order and
// the receiver cannot stall them.
module fermat_primality_test #(
   parameter int OPERAND_WIDTH = fpt_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [OPERAND_WIDTH-1:0] req_base,
   input  wire logic [OPERAND_WIDTH-1:0] req_modulus,
   output logic                          rsp_valid,
   output logic                          rsp_passes,
   output logic                          rsp_bad_modulus
);
   import fpt_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int NM = W * W;

   logic         rv [W+1];
   logic [W-1:0] rb [W+1];
   logic [W-1:0] rp [W+1];
   logic [W-1:0] rr [W+1];

   logic         mv [NM+1];
   logic [W-1:0] mp [NM+1];
   logic [W-1:0] ma [NM+1];
   logic [W-1:0] mc [NM+1];
   logic [W-1:0] ms [NM+1];
   logic [W-1:0] m1 [NM+1];
   logic [W-1:0] m2 [NM+1];

   logic valid_ff, passes_ff, bad_ff;

   assign busy  = 1'b0;
   assign rv[0] = start;
   assign rb[0] = req_base;
   assign rp[0] = req_modulus;
   assign rr[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_red
      fpt_red_cell #(.OPERAND_WIDTH(W), .BIT(W - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_i   (rv[i]),
         .base_i    (rb[i]),
         .modulus_i (rp[i]),
         .rem_i     (rr[i]),
         .valid_o   (rv[i+1]),
         .base_o    (rb[i+1]),
         .modulus_o (rp[i+1]),
         .rem_o     (rr[i+1])
      );
   end

   assign mv[0] = rv[W];
   assign mp[0] = rp[W];
   assign ma[0] = rr[W];
   assign mc[0] = (rp[W] == W'(1)) ? '0 : W'(1);
   assign ms[0] = rr[W];
   assign m1[0] = '0;
   assign m2[0] = '0;

   for (genvar e = 0; e < W; e++) begin : g_exp
      for (genvar j = 0; j < W; j++) begin : g_bit
         localparam int K = e * W + j;
         fpt_mul_cell #(.OPERAND_WIDTH(W), .BIT(W - 1 - j), .EXP(e)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_i   (mv[K]),
            .modulus_i (mp[K]),
            .ared_i    (ma[K]),
            .acc_i     (mc[K]),
            .sq_i      (ms[K]),
            .r1_i      (m1[K]),
            .r2_i      (m2[K]),
            .valid_o   (mv[K+1]),
            .modulus_o (mp[K+1]),
            .ared_o    (ma[K+1]),
            .acc_o     (mc[K+1]),
            .sq_o      (ms[K+1]),
            .r1_o      (m1[K+1]),
            .r2_o      (m2[K+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= mv[NM];
      end
      bad_ff    <= (mp[NM] == '0);
      passes_ff <= (mp[NM] != '0) && (mc[NM] == ma[NM]);
   end

   assign rsp_valid       = valid_ff;
   assign rsp_passes      = passes_ff;
   assign rsp_bad_modulus = bad_ff;
endmodule
`default_nettype wire
